>>> rtl/core/ttu_pkg.sv
// ----------------------------------------------------------------------------
// ttu_pkg
// shared types, constants and helpers for the text to unsigned integer parser
// ----------------------------------------------------------------------------
package ttu_pkg;

    localparam int MAX_CHARS  = 4096;
    localparam int OFFSET_W   = 13;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_DATA_W = ((VALUE_W + OFFSET_W + STATUS_W + 7) / 8) * 8;

    localparam logic [BASE_W-1:0]   BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0]   BASE_AUTO  = BASE_W'(0);
    localparam logic [BASE_W-1:0]   BASE_OCT   = BASE_W'(8);
    localparam logic [BASE_W-1:0]   BASE_DEC   = BASE_W'(10);
    localparam logic [BASE_W-1:0]   BASE_HEX   = BASE_W'(16);
    localparam logic [BASE_W-1:0]   BASE_MAX   = BASE_W'(36);
    localparam logic [DIGIT_W-1:0]  NO_DIGIT   = '1;
    localparam logic [OFFSET_W-1:0] POS_LIMIT  = OFFSET_W'(MAX_CHARS);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } t_ttu_phase;

    typedef enum logic [2:0] {
        CLS_NUL   = 3'd0,
        CLS_SPACE = 3'd1,
        CLS_PLUS  = 3'd2,
        CLS_MINUS = 3'd3,
        CLS_X     = 3'd4,
        CLS_OTHER = 3'd5
    } t_ttu_class;

    // classified character as it sits in the queue
    typedef struct packed {
        t_ttu_class           cls;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
    } t_ttu_item;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [OFFSET_W-1:0]  end_offset;
        logic [STATUS_W-1:0]  status;
    } t_ttu_result;

    function automatic logic ttu_base_invalid(input logic [BASE_W-1:0] b);
        return (b == BASE_W'(1)) || (b > BASE_MAX);
    endfunction

endpackage

>>> rtl/core/text_to_unsigned_integer.sv
// ----------------------------------------------------------------------------
// text_to_unsigned_integer
// streaming strtoul-style parser, radix 2..36 or automatic prefix detection
// ----------------------------------------------------------------------------
// channel   direction  word                    fields (low bit up)
// s_axis    in         8-bit tdata + tlast     char_code | tlast: is_last
// m_axis    out        80-bit tdata            value, end_offset, status
// cfg       in         6-bit data              number_base
//
// one character per cycle while m_axis keeps up; the result is registered and appears
// on m_axis in the cycle after the last-marked character is taken by the parse engine.
// the cycle time is set by the 64 by 6 bit radix multiply-add in the engine.
// reset is synchronous, active low; no clearing pass, items taken right away.
// a stalled m_axis holds one result; the 4-word queue keeps s_axis open until full.
// number_base is sampled by the engine at the first character of each string.
// ----------------------------------------------------------------------------
module text_to_unsigned_integer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ttu_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] char_code
    input  logic                           s_axis_tlast,
    // stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ttu_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // value, end_offset, status, pad
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ttu_pkg::BASE_W-1:0]     i_cfg_data     // number_base
);
    import ttu_pkg::*;

    logic [BASE_W-1:0] r_number_base;
    logic              push;
    logic              pop;
    logic              fifo_empty;
    logic              fifo_full;
    t_ttu_item         front_item;
    t_ttu_item         back_item;
    t_ttu_result       res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (i_cfg_valid) begin
            r_number_base <= i_cfg_data;
        end
    end

    ttu_front u_front (
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (fifo_full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_item  (front_item)
    );

    ttu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (back_item),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    ttu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_number_base),
        .i_item      (back_item),
        .i_empty     (fifo_empty),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = OUT_DATA_W'({res.status, res.end_offset, res.value});

endmodule

>>> rtl/core/ttu_front.sv
// ----------------------------------------------------------------------------
// ttu_front
// accepts characters and classifies them into digit value and character kind
// ----------------------------------------------------------------------------
module ttu_front (
    input  logic                       i_valid,
    input  logic [ttu_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_last,
    input  logic                       i_full,
    output logic                       o_ready,
    output logic                       o_push,
    output ttu_pkg::t_ttu_item         o_item
);
    import ttu_pkg::*;

    logic [CHAR_W-1:0] digit_full;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            digit_full = i_char - 8'h30;
        end else if (i_char >= 8'h61 && i_char <= 8'h7A) begin
            digit_full = i_char - 8'h61 + 8'd10;
        end else if (i_char >= 8'h41 && i_char <= 8'h5A) begin
            digit_full = i_char - 8'h41 + 8'd10;
        end else begin
            digit_full = CHAR_W'(NO_DIGIT);
        end
    end

    always_comb begin
        o_item.digit = digit_full[DIGIT_W-1:0];
        o_item.last  = i_last;
        if (i_char == 8'h00) begin
            o_item.cls = CLS_NUL;
        end else if (i_char == 8'h20 || (i_char >= 8'h09 && i_char <= 8'h0D)) begin
            o_item.cls = CLS_SPACE;
        end else if (i_char == 8'h2B) begin
            o_item.cls = CLS_PLUS;
        end else if (i_char == 8'h2D) begin
            o_item.cls = CLS_MINUS;
        end else if (i_char == 8'h78 || i_char == 8'h58) begin
            o_item.cls = CLS_X;
        end else begin
            o_item.cls = CLS_OTHER;
        end
    end

endmodule

>>> rtl/core/ttu_fifo.sv
// ----------------------------------------------------------------------------
// ttu_fifo
// short queue of classified characters between front and back
// ----------------------------------------------------------------------------
module ttu_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ttu_pkg::t_ttu_item  i_item,
    input  logic                i_pop,
    output ttu_pkg::t_ttu_item  o_item,
    output logic                o_empty,
    output logic                o_full
);
    import ttu_pkg::*;

    t_ttu_item           r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_CW-1:0]  r_count;
    logic [FIFO_AW-1:0]  n_wr_ptr;
    logic [FIFO_AW-1:0]  n_rd_ptr;
    logic [FIFO_CW-1:0]  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

>>> rtl/core/ttu_back.sv
// ----------------------------------------------------------------------------
// ttu_back
// parse engine: prefix and sign handling, radix multiply-add, result register
// ----------------------------------------------------------------------------
module ttu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ttu_pkg::BASE_W-1:0] i_base,
    input  ttu_pkg::t_ttu_item         i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output ttu_pkg::t_ttu_result       o_res
);
    import ttu_pkg::*;

    t_ttu_phase            r_phase, n_phase;
    logic [OFFSET_W-1:0]   r_pos, n_pos;
    logic [VALUE_W-1:0]    r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic                  r_neg, n_neg;
    logic [BASE_W-1:0]     r_base, n_base;
    logic [OFFSET_W-1:0]   r_subj, n_subj;

    // result register, value negated on the way out after a minus sign
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_acc;
    logic [OFFSET_W-1:0]   r_out_subj;
    logic                  r_out_neg;
    logic                  r_out_ovf;
    logic                  r_out_bad;

    logic                  first;
    logic [BASE_W-1:0]     base_eff;
    t_ttu_phase            ph;
    logic [OFFSET_W-1:0]   pos_inc;
    logic [BASE_W-1:0]     tbase;
    logic                  do_digit;
    logic [VALUE_W+BASE_W-1:0] prod;
    logic [VALUE_W:0]      sum;
    logic                  emit;

    assign o_pop = !i_empty && (!i_item.last || !r_out_valid || i_res_ready);
    assign emit  = o_pop && i_item.last;

    assign first    = (r_pos == '0) && (r_phase == PH_SPACE);
    assign base_eff = first ? i_base : r_base;
    assign pos_inc  = (r_pos < POS_LIMIT) ? r_pos + 1'b1 : POS_LIMIT;

    // one radix multiply-add per character
    assign prod = (VALUE_W + BASE_W)'(r_acc) * (VALUE_W + BASE_W)'(tbase);
    assign sum  = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W + 1)'(i_item.digit);

    always_comb begin
        ph       = (first && ttu_base_invalid(i_base)) ? PH_DONE : r_phase;
        n_phase  = ph;
        n_pos    = pos_inc;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_neg    = r_neg;
        n_base   = base_eff;
        n_subj   = r_subj;
        tbase    = base_eff;
        do_digit = 1'b0;

        if (i_item.cls == CLS_NUL) begin
            n_phase = PH_DONE;
        end else begin
            unique case (ph) inside
                PH_SPACE, PH_SIGN: begin
                    if (ph == PH_SPACE && i_item.cls == CLS_SPACE) begin
                        n_phase = PH_SPACE;
                    end else if (ph == PH_SPACE &&
                                 (i_item.cls == CLS_PLUS || i_item.cls == CLS_MINUS)) begin
                        n_neg   = (i_item.cls == CLS_MINUS);
                        n_phase = PH_SIGN;
                    end else if (i_item.digit == '0) begin
                        n_subj  = pos_inc;
                        n_phase = PH_ZERO;
                    end else begin
                        tbase    = (base_eff == BASE_AUTO) ? BASE_DEC : base_eff;
                        n_base   = tbase;
                        do_digit = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if ((base_eff == BASE_AUTO || base_eff == BASE_HEX) &&
                        i_item.cls == CLS_X) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_DIGITS;
                    end else begin
                        tbase    = (base_eff == BASE_AUTO) ? BASE_OCT : base_eff;
                        n_base   = tbase;
                        do_digit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                default: begin
                    n_phase = ph;
                end
            endcase
        end

        if (do_digit) begin
            if (tbase < BASE_W'(2) || i_item.digit >= tbase) begin
                n_phase = PH_DONE;
            end else begin
                if ((|prod[VALUE_W+BASE_W-1:VALUE_W]) || sum[VALUE_W]) begin
                    n_ovf = 1'b1;
                end
                n_acc   = sum[VALUE_W-1:0];
                n_subj  = pos_inc;
                n_phase = PH_DIGITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_pos       <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_subj      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_phase <= PH_SPACE;
                r_pos   <= '0;
                r_acc   <= '0;
                r_ovf   <= 1'b0;
                r_neg   <= 1'b0;
                r_base  <= '0;
                r_subj  <= '0;
            end else if (o_pop) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_subj  <= n_subj;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_acc  <= n_acc;
            r_out_subj <= n_subj;
            r_out_neg  <= n_neg;
            r_out_ovf  <= n_ovf;
            r_out_bad  <= ttu_base_invalid(n_base);
        end
    end

    assign o_res_valid = r_out_valid;

    always_comb begin
        if (r_out_bad) begin
            o_res.value      = '0;
            o_res.end_offset = '0;
            o_res.status     = ST_BAD_BASE;
        end else if (r_out_ovf) begin
            o_res.value      = '1;
            o_res.end_offset = r_out_subj;
            o_res.status     = ST_OVERFLOW;
        end else begin
            o_res.value      = r_out_neg ? ('0 - r_out_acc) : r_out_acc;
            o_res.end_offset = r_out_subj;
            o_res.status     = ST_OK;
        end
    end

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_phase == PH_SPACE && r_pos == '0 && !r_ovf && r_acc == '0))
        else $error("string state not cleared after result");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_LIMIT) && (r_subj <= r_pos))
        else $error("position beyond limit or subject past position");

    a_bad_base_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0 && ttu_base_invalid(r_base)) |-> (r_phase == PH_DONE))
        else $error("invalid base but parse still running");

    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |=> (r_out_valid && $stable(r_out_acc)))
        else $error("pending result overwritten");

endmodule
